FILE: hw/rtl/sphere_cylinder_pushout_macros.svh
// assertion macros for the sphere/cylinder push-out block
// used by the checker; needs clk and rst_n in the scope of use
`ifndef SPHERE_CYLINDER_PUSHOUT_MACROS_SVH
`define SPHERE_CYLINDER_PUSHOUT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SCP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scp check failed");

// antecedent implies consequent in the next cycle
`define SCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scp check failed");

`endif

FILE: hw/rtl/scp_pkg.sv
// shared types and widths for the sphere/cylinder push-out pipeline
// no dependencies
`default_nettype none

package scp_pkg;

    localparam int DATA_W = 32;
    localparam int RAD_W  = 31;
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;

    // one collision request as unpacked from the input stream
    typedef struct packed {
        logic [DATA_W-1:0] sx;
        logic [DATA_W-1:0] sy;
        logic [DATA_W-1:0] sz;
        logic [RAD_W-1:0]  sr;
        logic [DATA_W-1:0] cx;
        logic [DATA_W-1:0] cy;
        logic [DATA_W-1:0] cz;
        logic [RAD_W-1:0]  cr;
        logic [RAD_W-1:0]  ch;
    } scp_in_t;

    // per-request control carried down the whole pipeline
    typedef struct packed {
        logic              hit;
        logic              zero;
        logic [DATA_W-1:0] sx;
        logic [DATA_W-1:0] sy;
        logic [DATA_W-1:0] sz;
        logic              negx;
        logic              negz;
    } scp_tag_t;

    // control plus dividends carried through the square root
    typedef struct packed {
        scp_tag_t        tag;
        logic [SQ_W-1:0] px;
        logic [SQ_W-1:0] pz;
    } scp_sq_side_t;

endpackage

`default_nettype wire

FILE: hw/rtl/scp_front.sv
// front stages: deltas, height test, squares and products, distance test
// depends on scp_pkg
`default_nettype none

module scp_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire logic                   in_vld,
    input  wire scp_pkg::scp_in_t       in_d,
    output logic                        out_vld,
    output scp_pkg::scp_sq_side_t       out_side,
    output logic [scp_pkg::SQ_W-1:0]    out_d2
);

    // stage 1 registers
    logic        vld1_reg;
    logic [31:0] sx1_reg, sy1_reg, sz1_reg;
    logic [32:0] ax1_reg, az1_reg;
    logic        negx1_reg, negz1_reg, miss1_reg;
    logic [31:0] r1_reg;

    // stage 2 registers
    logic        vld2_reg;
    logic [31:0] sx2_reg, sy2_reg, sz2_reg;
    logic        negx2_reg, negz2_reg, miss2_reg;
    logic [63:0] sqx2_reg, sqz2_reg, rr2_reg, px2_reg, pz2_reg;

    // stage 3 registers
    logic                  vld3_reg;
    scp_pkg::scp_sq_side_t side3_reg;
    logic [63:0]           d23_reg;

    // stage 1 logic
    logic signed [32:0] vx_next, vz_next;
    logic signed [33:0] sy_e, cy_e, low_e, high_e, top_e;
    logic               miss1_next;
    logic [31:0]        r1_next;

    always_comb
    begin
        vx_next    = $signed({in_d.cx[31], in_d.cx}) - $signed({in_d.sx[31], in_d.sx});
        vz_next    = $signed({in_d.cz[31], in_d.cz}) - $signed({in_d.sz[31], in_d.sz});
        sy_e       = $signed({{2{in_d.sy[31]}}, in_d.sy});
        cy_e       = $signed({{2{in_d.cy[31]}}, in_d.cy});
        low_e      = sy_e + $signed({3'b000, in_d.sr});
        high_e     = sy_e - $signed({3'b000, in_d.sr});
        top_e      = cy_e + $signed({3'b000, in_d.ch});
        miss1_next = (low_e < cy_e) || (high_e > top_e);
        r1_next    = {1'b0, in_d.sr} + {1'b0, in_d.cr};
    end

    // stage 2 logic
    logic [31:0] ax32, az32;
    logic        miss2_next;

    always_comb
    begin
        ax32       = ax1_reg[31:0];
        az32       = az1_reg[31:0];
        miss2_next = miss1_reg || (ax1_reg > {1'b0, r1_reg}) || (az1_reg > {1'b0, r1_reg});
    end

    // stage 3 logic
    logic [64:0] d2_sum;

    always_comb
    begin
        d2_sum = {1'b0, sqx2_reg} + {1'b0, sqz2_reg};
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx1_reg   <= in_d.sx;
            sy1_reg   <= in_d.sy;
            sz1_reg   <= in_d.sz;
            ax1_reg   <= vx_next[32] ? 33'(-vx_next) : 33'(vx_next);
            az1_reg   <= vz_next[32] ? 33'(-vz_next) : 33'(vz_next);
            negx1_reg <= vx_next[32];
            negz1_reg <= vz_next[32];
            miss1_reg <= miss1_next;
            r1_reg    <= r1_next;

            sx2_reg   <= sx1_reg;
            sy2_reg   <= sy1_reg;
            sz2_reg   <= sz1_reg;
            negx2_reg <= negx1_reg;
            negz2_reg <= negz1_reg;
            miss2_reg <= miss2_next;
            sqx2_reg  <= 64'(ax32) * 64'(ax32);
            sqz2_reg  <= 64'(az32) * 64'(az32);
            rr2_reg   <= 64'(r1_reg) * 64'(r1_reg);
            px2_reg   <= 64'(ax32) * 64'(r1_reg);
            pz2_reg   <= 64'(az32) * 64'(r1_reg);

            side3_reg.tag.hit  <= !miss2_reg && !d2_sum[64] && (d2_sum[63:0] <= rr2_reg);
            side3_reg.tag.zero <= (d2_sum == 65'd0);
            side3_reg.tag.sx   <= sx2_reg;
            side3_reg.tag.sy   <= sy2_reg;
            side3_reg.tag.sz   <= sz2_reg;
            side3_reg.tag.negx <= negx2_reg;
            side3_reg.tag.negz <= negz2_reg;
            side3_reg.px       <= px2_reg;
            side3_reg.pz       <= pz2_reg;
            d23_reg            <= d2_sum[63:0];
        end
    end

    assign out_vld  = vld3_reg;
    assign out_side = side3_reg;
    assign out_d2   = d23_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/scp_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on scp_pkg
`default_nettype none

module scp_sqrt (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire logic                   in_vld,
    input  wire scp_pkg::scp_sq_side_t  in_side,
    input  wire logic [scp_pkg::SQ_W-1:0] in_val,
    output logic                        out_vld,
    output scp_pkg::scp_sq_side_t       out_side,
    output logic [scp_pkg::ROOT_W-1:0]  out_root
);

    localparam int N = scp_pkg::ROOT_W;

    logic                  vld_reg  [0:N-1];
    scp_pkg::scp_sq_side_t side_reg [0:N-1];
    logic [N:0]            rem_reg  [0:N-1];
    logic [N-1:0]          root_reg [0:N-1];
    logic [2*N-1:0]        val_reg  [0:N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic                  vld_in;
            scp_pkg::scp_sq_side_t side_in;
            logic [N:0]            rem_in;
            logic [N-1:0]          root_in;
            logic [2*N-1:0]        val_in;
            logic [N+2:0]          rem2;
            logic [N+2:0]          trial;
            logic                  ge;

            if (k == 0)
            begin : g_first
                assign vld_in  = in_vld;
                assign side_in = in_side;
                assign rem_in  = '0;
                assign root_in = '0;
                assign val_in  = in_val;
            end
            else
            begin : g_next
                assign vld_in  = vld_reg[k-1];
                assign side_in = side_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign val_in  = val_reg[k-1];
            end

            // bring down two bits and try subtracting 4*root+1
            always_comb
            begin
                rem2  = {rem_in, val_in[2*N-1:2*N-2]};
                trial = {1'b0, root_in, 2'b01};
                ge    = (rem2 >= trial);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (adv)
                    vld_reg[k] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    side_reg[k] <= side_in;
                    rem_reg[k]  <= ge ? (N+1)'(rem2 - trial) : rem2[N:0];
                    root_reg[k] <= {root_in[N-2:0], ge};
                    val_reg[k]  <= {val_in[2*N-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[N-1];
    assign out_side = side_reg[N-1];
    assign out_root = root_reg[N-1];

endmodule

`default_nettype wire

FILE: hw/rtl/scp_div.sv
// pipelined restoring divider, two lanes sharing one divisor
// depends on scp_pkg; quotient must fit in ROOT_W bits
`default_nettype none

module scp_div (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   adv,
    input  wire logic                   in_vld,
    input  wire scp_pkg::scp_sq_side_t  in_side,
    input  wire logic [scp_pkg::ROOT_W-1:0] in_den,
    output logic                        out_vld,
    output scp_pkg::scp_tag_t           out_tag,
    output logic [scp_pkg::ROOT_W-1:0]  out_qx,
    output logic [scp_pkg::ROOT_W-1:0]  out_qz
);

    localparam int N = scp_pkg::ROOT_W;

    logic              vld_reg [0:N-1];
    scp_pkg::scp_tag_t tag_reg [0:N-1];
    logic [N-1:0]      den_reg [0:N-1];
    logic [N-1:0]      remx_reg[0:N-1];
    logic [N-1:0]      lowx_reg[0:N-1];
    logic [N-1:0]      remz_reg[0:N-1];
    logic [N-1:0]      lowz_reg[0:N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic              vld_in;
            scp_pkg::scp_tag_t tag_in;
            logic [N-1:0]      den_in, remx_in, lowx_in, remz_in, lowz_in;
            logic [N:0]        rx2, rz2;
            logic              gex, gez;

            if (k == 0)
            begin : g_first
                assign vld_in  = in_vld;
                assign tag_in  = in_side.tag;
                assign den_in  = in_den;
                assign remx_in = in_side.px[2*N-1:N];
                assign lowx_in = in_side.px[N-1:0];
                assign remz_in = in_side.pz[2*N-1:N];
                assign lowz_in = in_side.pz[N-1:0];
            end
            else
            begin : g_next
                assign vld_in  = vld_reg[k-1];
                assign tag_in  = tag_reg[k-1];
                assign den_in  = den_reg[k-1];
                assign remx_in = remx_reg[k-1];
                assign lowx_in = lowx_reg[k-1];
                assign remz_in = remz_reg[k-1];
                assign lowz_in = lowz_reg[k-1];
            end

            // shift in one dividend bit and compare against the divisor
            always_comb
            begin
                rx2 = {remx_in, lowx_in[N-1]};
                rz2 = {remz_in, lowz_in[N-1]};
                gex = (rx2 >= {1'b0, den_in});
                gez = (rz2 >= {1'b0, den_in});
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else if (adv)
                    vld_reg[k] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    tag_reg[k]  <= tag_in;
                    den_reg[k]  <= den_in;
                    remx_reg[k] <= gex ? N'(rx2 - {1'b0, den_in}) : rx2[N-1:0];
                    remz_reg[k] <= gez ? N'(rz2 - {1'b0, den_in}) : rz2[N-1:0];
                    lowx_reg[k] <= {lowx_in[N-2:0], gex};
                    lowz_reg[k] <= {lowz_in[N-2:0], gez};
                end
            end
        end
    endgenerate

    assign out_vld = vld_reg[N-1];
    assign out_tag = tag_reg[N-1];
    assign out_qx  = lowx_reg[N-1];
    assign out_qz  = lowz_reg[N-1];

endmodule

`default_nettype wire

FILE: hw/rtl/sphere_cylinder_pushout.sv
// path from request accept to result valid: front, square-root and divide stages, then the output register
// throughput: one request per cycle; the whole pipeline holds when the output is stalled
// reset: rst_n asynchronous active low, clears every stage valid bit; no clearing pass
// depends on scp_pkg, scp_front, scp_sqrt, scp_div
`default_nettype none

module sphere_cylinder_pushout (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // sphere_x, sphere_y, sphere_z, sphere_rad, cyl_x, cyl_y, cyl_z, cyl_rad, cyl_height, pad
    input  wire logic [287:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // push_x, push_y, push_z
    output logic [95:0]       m_tdata,
    // hit
    output logic [0:0]        m_tuser
);

    localparam int N = scp_pkg::ROOT_W;

    logic                  adv;
    scp_pkg::scp_in_t      in_d;
    logic                  f_vld, q_vld, d_vld;
    scp_pkg::scp_sq_side_t f_side, q_side;
    logic [63:0]           f_d2;
    logic [N-1:0]          q_root, qx, qz;
    scp_pkg::scp_tag_t     d_tag;

    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic        hit_reg;

    // global advance: move when the output slot is free or being taken
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // unpack the request
    always_comb
    begin
        in_d.sx = s_tdata[31:0];
        in_d.sy = s_tdata[63:32];
        in_d.sz = s_tdata[95:64];
        in_d.sr = s_tdata[126:96];
        in_d.cx = s_tdata[158:127];
        in_d.cy = s_tdata[190:159];
        in_d.cz = s_tdata[222:191];
        in_d.cr = s_tdata[253:223];
        in_d.ch = s_tdata[284:254];
    end

    scp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (s_tvalid),
        .in_d     (in_d),
        .out_vld  (f_vld),
        .out_side (f_side),
        .out_d2   (f_d2)
    );

    scp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (f_vld),
        .in_side  (f_side),
        .in_val   (f_d2),
        .out_vld  (q_vld),
        .out_side (q_side),
        .out_root (q_root)
    );

    scp_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (q_vld),
        .in_side (q_side),
        .in_den  (q_root),
        .out_vld (d_vld),
        .out_tag (d_tag),
        .out_qx  (qx),
        .out_qz  (qz)
    );

    // apply the offsets and saturate
    logic signed [33:0] sum_x, sum_z;
    logic [31:0]        px_sat, pz_sat;

    always_comb
    begin
        sum_x = $signed({{2{d_tag.sx[31]}}, d_tag.sx});
        sum_z = $signed({{2{d_tag.sz[31]}}, d_tag.sz});
        if (d_tag.negx)
            sum_x = sum_x - $signed({2'b00, qx});
        else
            sum_x = sum_x + $signed({2'b00, qx});
        if (d_tag.negz)
            sum_z = sum_z - $signed({2'b00, qz});
        else
            sum_z = sum_z + $signed({2'b00, qz});

        if (sum_x > 34'sh0_7FFF_FFFF)
            px_sat = 32'h7FFF_FFFF;
        else if (sum_x < -34'sh0_8000_0000)
            px_sat = 32'h8000_0000;
        else
            px_sat = sum_x[31:0];

        if (sum_z > 34'sh0_7FFF_FFFF)
            pz_sat = 32'h7FFF_FFFF;
        else if (sum_z < -34'sh0_8000_0000)
            pz_sat = 32'h8000_0000;
        else
            pz_sat = sum_z[31:0];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (adv)
            m_tvalid_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= d_tag.hit;
            if (!d_tag.hit)
                m_tdata_reg <= '0;
            else if (d_tag.zero)
                m_tdata_reg <= {d_tag.sz, d_tag.sy, d_tag.sx};
            else
                m_tdata_reg <= {pz_sat, d_tag.sy, px_sat};
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = hit_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/scp_checker.sv
// port-level checks for the sphere/cylinder push-out block, bound to the top level
// depends on sphere_cylinder_pushout_macros.svh
`default_nettype none

`include "sphere_cylinder_pushout_macros.svh"

module scp_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [287:0] s_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [95:0]  m_tdata,
    input wire logic [0:0]   m_tuser
);

    // a stalled result holds
    `SCP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // a waiting request holds
    `SCP_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata))
    // a miss carries all-zero coordinates
    `SCP_ASSERT_SAME(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == 96'd0)
    // input is taken exactly when the output slot can move
    `SCP_ASSERT_SAME(a_ready_link, 1'b1, s_tready == (!m_tvalid || m_tready))

endmodule

bind sphere_cylinder_pushout scp_checker u_scp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: dv/sphere_cylinder_pushout_tb.sv
// self-checking bench for the sphere/cylinder push-out pipeline
// depends on sphere_cylinder_pushout and scp_pkg; needs no files or arguments
`default_nettype none

module sphere_cylinder_pushout_tb;

    localparam int LATENCY   = 68;
    localparam int N_RANDOM  = 1300;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic        hit;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
    } push_t;

    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sz;
        logic [30:0] sr;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [30:0] cr;
        logic [30:0] ch;
    } pair_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [0:0]   m_tuser;

    pair_t  pending_pairs[$];
    push_t  expected_pushes[$];
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_send;
    bit     stim_done;
    int     mismatches;
    int     results_seen;
    int     hits_seen;
    longint cycles;

    sphere_cylinder_pushout uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // integer square root, floor
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'h7fffffff;
        if (v < -66'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    // centre moved along one axis by |delta|*r/span_len
    function automatic logic [31:0] push_along(input logic signed [33:0] centre,
                                               input logic signed [33:0] delta,
                                               input logic [63:0] r,
                                               input logic [63:0] span_len);
        logic [63:0]  mag;
        logic [127:0] quot;
        logic signed [65:0] sum;
        mag  = (delta < 0) ? 64'(-delta) : 64'(delta);
        quot = (128'(mag) * 128'(r)) / 128'(span_len);
        if (delta < 0)
            sum = 66'(centre) - $signed({2'b00, quot[63:0]});
        else
            sum = 66'(centre) + $signed({2'b00, quot[63:0]});
        return clamp32(sum);
    endfunction

    // expected push-out for one sphere/cylinder pair
    function automatic push_t predict_push(input pair_t p);
        push_t res;
        logic signed [33:0] sx, sy, sz, cx, cy, cz, sr, cr, ch, vx, vz;
        logic [63:0] r, ax, az, root_d;
        logic [128:0] d2, r2;
        res = '0;
        sx = 34'($signed(p.sx));
        sy = 34'($signed(p.sy));
        sz = 34'($signed(p.sz));
        cx = 34'($signed(p.cx));
        cy = 34'($signed(p.cy));
        cz = 34'($signed(p.cz));
        sr = $signed({3'b000, p.sr});
        cr = $signed({3'b000, p.cr});
        ch = $signed({3'b000, p.ch});
        r  = 64'(sr + cr);
        vx = cx - sx;
        vz = cz - sz;
        ax = (vx < 0) ? 64'(-vx) : 64'(vx);
        az = (vz < 0) ? 64'(-vz) : 64'(vz);
        if (sy + sr < cy || sy - sr > cy + ch)
            return res;
        d2 = 129'(ax) * 129'(ax) + 129'(az) * 129'(az);
        r2 = 129'(r) * 129'(r);
        if (d2 > r2)
            return res;
        res.hit = 1'b1;
        res.py  = p.sy;
        if (d2 == 0)
        begin
            res.px = p.sx;
            res.pz = p.sz;
            return res;
        end
        root_d = floor_sqrt(d2[63:0]);
        res.px = push_along(sx, vx, r, root_d);
        res.pz = push_along(sz, vz, r, root_d);
        return res;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int kind;
        logic [31:0] span;
        p = 285'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom});
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            // mostly overlapping pairs near each other, so hits dominate
            span = 32'd1 << $urandom_range(4, 30);
            p.sr = 31'($urandom_range(0, span));
            p.cr = 31'($urandom_range(0, span));
            p.ch = 31'($urandom_range(0, span)) << $urandom_range(0, 1);
            p.cx = p.sx + 32'($signed($urandom_range(0, 2 * span)) - $signed(span));
            p.cz = p.sz + 32'($signed($urandom_range(0, 2 * span)) - $signed(span));
            p.cy = p.sy - 32'($urandom_range(0, span));
            if (kind == 6)
                p.cx = p.sx;
        end
        return p;
    endfunction

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || expected_pushes.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        pair_t p;
        stim_done      = 1'b0;
        hold_send      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: coincident, touching, height bounds, extremes
        p = '0; p.sr = 31'd100; p.cr = 31'd50; p.ch = 31'd10;
        pending_pairs.push_back(p);
        p.cx = 32'd150;
        pending_pairs.push_back(p);
        p.cx = 32'd151;
        pending_pairs.push_back(p);
        p.cx = -32'sd150;
        pending_pairs.push_back(p);
        p.cx = 32'd90; p.cz = -32'sd120;
        pending_pairs.push_back(p);
        p.cx = 32'd0; p.cz = 32'd0; p.cy = 32'd100;
        pending_pairs.push_back(p);
        p.cy = 32'd101;
        pending_pairs.push_back(p);
        p.cy = -32'sd110;
        pending_pairs.push_back(p);
        p.cy = -32'sd111;
        pending_pairs.push_back(p);
        p = '0; p.sx = 32'h7fffffff; p.sz = 32'h80000000; p.sr = '1; p.cr = '1;
        p.ch = '1; p.cx = 32'h7ffffff0; p.cz = 32'h80000010; p.cy = 32'h80000000;
        pending_pairs.push_back(p);
        p.sx = 32'h80000000; p.cx = 32'h7fffffff; p.sz = 32'h7fffffff;
        p.cz = 32'h80000000;
        pending_pairs.push_back(p);
        p = '1;
        pending_pairs.push_back(p);
        p = '0; p.sx = 32'h7fff0000; p.cx = 32'h7fff0001; p.sr = '1;
        pending_pairs.push_back(p);
        p = '0; p.sx = 32'h80000100; p.cx = 32'h800000ff; p.cz = 32'd1; p.cr = '1;
        pending_pairs.push_back(p);
        p = '0; p.sy = 32'h7fffffff; p.cy = 32'h80000000; p.ch = '1; p.sr = '1;
        pending_pairs.push_back(p);
        wait_drained();

        // random phases with different idle mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (int i = 0; i < N_RANDOM / 4; i++)
                pending_pairs.push_back(random_pair());
            // hold the sender once until all results are back
            if (ph == 3)
            begin
                while (pending_pairs.size() > N_RANDOM / 8)
                    @(posedge clk);
                hold_send = 1'b1;
                while (expected_pushes.size() != 0)
                    @(posedge clk);
                hold_send = 1'b0;
            end
            while (pending_pairs.size() != 0)
                @(posedge clk);
        end
        wait_drained();
        stim_done = 1'b1;
    end

    // driver: the head of the queue is on the bus until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        pair_t q;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_pushes.push_back(predict_push(pending_pairs.pop_front()));
            end
            if ((!s_tvalid || s_tready) && pending_pairs.size() != 0
                && !hold_send && $urandom_range(0, 99) >= send_idle_pct)
            begin
                q = pending_pairs[0];
                s_tvalid <= 1'b1;
                // lowest field first on the bus
                s_tdata  <= {3'd0, q.ch, q.cr, q.cz, q.cy, q.cx, q.sr, q.sz, q.sy, q.sx};
            end
            else if (s_tready)
                s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        push_t got;
        push_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_tvalid && m_tready)
            begin
                got = {m_tuser[0], m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]};
                results_seen++;
                if (expected_pushes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result hit=%0b data=%h", got.hit, m_tdata);
                end
                else
                begin
                    want = expected_pushes.pop_front();
                    hits_seen += want.hit;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp hit=%0b x=%h y=%h z=%h ",
                                      "got hit=%0b x=%h y=%h z=%h"},
                                     want.hit, want.px, want.py, want.pz,
                                     got.hit, got.px, got.py, got.pz);
                    end
                end
            end
        end
    end

    // end of run and timeout
    initial
    begin
        mismatches   = 0;
        results_seen = 0;
        hits_seen    = 0;
        cycles       = 0;
        while (!stim_done && cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (!stim_done)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("sphere_cylinder_pushout_tb: done, errors");
        end
        else
        begin
            $display("checked %0d push-out results (%0d hits) under four idle/stall mixes",
                     results_seen, hits_seen);
            if (mismatches == 0 && expected_pushes.size() == 0)
                $display("sphere_cylinder_pushout_tb: done, clean");
            else
                $display("sphere_cylinder_pushout_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
